>>> design/icm_pkg.sv
// shared constants and types for the id compress and map block
package icm_pkg;
    localparam int MaxIdsDefault = 32;
    localparam int IdW = 64;
    localparam int PosW = 6;
    localparam int CidxW = 7;
    localparam int CntW = 7;

    // controller commands to the datapath
    typedef struct packed {
        logic load;      // write the request id at the load pointer
        logic clr_load;  // clear load count and overflow
        logic sort_init; // start sorting pass
        logic sort_step; // one compare/shift step
        logic scan_step; // one distinct-count step
        logic rank_step; // clear the result index before emitting
        logic emit;      // drive one result
    } t_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic sort_done;
        logic scan_done;
        logic rank_done;
        logic emit_done;
        logic empty;
    } t_sts;
endpackage

>>> design/icm_dpath.sv
// datapath: id store, insertion sort, distinct scan and result generation
module icm_dpath import icm_pkg::*; #(
    parameter int MAX_IDS = MaxIdsDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [IdW-1:0]   i_id_value,
    output logic             o_strobe,
    output logic [PosW-1:0]  o_position,
    output logic [CidxW-1:0] o_compressed_index,
    output logic [IdW-1:0]   o_distinct_id,
    output logic             o_distinct_valid,
    output logic [CntW-1:0]  o_distinct_count,
    output logic             o_overflowed,
    output logic             o_last_result
);
    localparam int AW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
    localparam int CW = $clog2(MAX_IDS + 1);

    logic [IdW-1:0]   r_ids  [MAX_IDS];
    logic [AW-1:0]    r_ord  [MAX_IDS];
    logic [CidxW-1:0] r_rank [MAX_IDS];
    logic [IdW-1:0]   r_dist [MAX_IDS];

    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    // sort indices: outer i, inner j; k scan and emit index; key value held
    logic [CW-1:0]    r_i, r_j, r_k;
    logic [IdW-1:0]   r_key;
    logic [IdW-1:0]   r_prev;
    logic [CntW-1:0]  r_dcnt;

    logic [AW-1:0]    jm1;
    logic [IdW-1:0]   cmp_val;
    logic             shift;

    assign jm1 = AW'(r_j - CW'(1));
    assign cmp_val = r_ids[r_ord[jm1]];
    assign shift = (r_j != '0) && (cmp_val > r_key);

    assign o_sts.sort_done = (r_i >= r_cnt);
    assign o_sts.scan_done = (r_k >= r_cnt);
    assign o_sts.rank_done = 1'b1;
    assign o_sts.emit_done = (r_k + CW'(1) >= r_cnt);
    assign o_sts.empty = (r_cnt == '0);

    // load counter and overflow flag
    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (i_cmd.clr_load) begin
            n_cnt = '0;
            n_ovf = 1'b0;
        end else if (i_cmd.load) begin
            if (r_cnt < CW'(MAX_IDS)) n_cnt = r_cnt + CW'(1);
            else n_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

    // stores and sequencing registers
    always_ff @(posedge i_clk) begin
        o_strobe <= i_cmd.emit & i_rst_n;
        if (i_cmd.load && r_cnt < CW'(MAX_IDS))
            r_ids[AW'(r_cnt)] <= i_id_value;
        if (i_cmd.sort_init) begin
            r_i <= '0;
            r_j <= '0;
            r_key <= r_ids[0];
        end
        if (i_cmd.sort_step) begin
            if (shift) begin
                r_ord[AW'(r_j)] <= r_ord[jm1];
                r_j <= r_j - CW'(1);
            end else begin
                r_ord[AW'(r_j)] <= AW'(r_i);
                r_i <= r_i + CW'(1);
                r_j <= r_i + CW'(1);
                if (r_i + CW'(1) < CW'(MAX_IDS))
                    r_key <= r_ids[AW'(r_i + CW'(1))];
                r_k <= '0;
                r_prev <= '0;
                r_dcnt <= '0;
            end
        end
        // scan sorted order: count distinct, write rank per position
        if (i_cmd.scan_step) begin
            if (r_ids[r_ord[AW'(r_k)]] != r_prev) begin
                r_prev <= r_ids[r_ord[AW'(r_k)]];
                r_dist[AW'(r_dcnt)] <= r_ids[r_ord[AW'(r_k)]];
                r_dcnt <= r_dcnt + CntW'(1);
                r_rank[r_ord[AW'(r_k)]] <= r_dcnt;
            end else begin
                r_rank[r_ord[AW'(r_k)]] <= r_dcnt - CntW'(1);
            end
            r_k <= r_k + CW'(1);
        end
        if (i_cmd.rank_step)
            r_k <= '0;
        // one result per position
        if (i_cmd.emit) begin
            o_position <= PosW'(r_k);
            o_compressed_index <= r_rank[AW'(r_k)];
            o_distinct_valid <= (CntW'(r_k) < r_dcnt);
            o_distinct_id <= (CntW'(r_k) < r_dcnt) ? r_dist[AW'(r_k)] : '0;
            o_distinct_count <= r_dcnt;
            o_overflowed <= r_ovf;
            o_last_result <= (r_k + CW'(1) >= r_cnt);
            r_k <= r_k + CW'(1);
        end
    end
endmodule

>>> design/icm_ctrl.sv
// controller state machine sequencing load, sort, scan and emit
module icm_ctrl import icm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_is_last,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);
    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_SORT = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_PREP = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state, n_state;

    assign o_busy = (r_state != S_LOAD);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_is_last) n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.sort_init = 1'b1;
                n_state = S_SORT;
            end
            S_SORT: begin
                if (i_sts.sort_done) n_state = S_SCAN;
                else o_cmd.sort_step = 1'b1;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_PREP;
                else o_cmd.scan_step = 1'b1;
            end
            S_PREP: begin
                o_cmd.rank_step = 1'b1;
                n_state = i_sts.empty ? S_DONE : S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.emit_done) n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.clr_load = 1'b1;
                n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_LOAD;
        else r_state <= n_state;
    end
endmodule

>>> design/id_compress_and_map_core.sv
// id compress and map: load a set of ids, sort, count distinct, emit ranks
// after the closing request of n ids: insertion sort (0 to n*(n-1)/2 shifts),
// distinct scan, then one result per cycle
// one request per cycle while loading; busy high from closing request to last result
// synchronous active-low reset returns to loading with an empty set
// results carry a one-cycle strobe; the receiver cannot stall
module id_compress_and_map_core import icm_pkg::*; #(
    parameter int MAX_IDS = MaxIdsDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [IdW-1:0]   i_id_value,
    input  logic             i_is_last,
    output logic             o_strobe,
    output logic [PosW-1:0]  o_position,
    output logic [CidxW-1:0] o_compressed_index,
    output logic [IdW-1:0]   o_distinct_id,
    output logic             o_distinct_valid,
    output logic [CntW-1:0]  o_distinct_count,
    output logic             o_overflowed,
    output logic             o_last_result
);
    t_cmd cmd;
    t_sts sts;

    icm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_is_last(i_is_last),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy)
    );

    icm_dpath #(.MAX_IDS(MAX_IDS)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_id_value(i_id_value), .o_strobe(o_strobe), .o_position(o_position),
        .o_compressed_index(o_compressed_index), .o_distinct_id(o_distinct_id),
        .o_distinct_valid(o_distinct_valid), .o_distinct_count(o_distinct_count),
        .o_overflowed(o_overflowed), .o_last_result(o_last_result)
    );
endmodule

>>> test/id_compress_and_map_core_tb.sv
// self-checking testbench for the id compress and map core
module id_compress_and_map_core_tb;
    import icm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxIds = MaxIdsDefault;

    // one expected result
    typedef struct {
        logic [PosW-1:0]  position;
        logic [CidxW-1:0] cidx;
        logic [IdW-1:0]   did;
        logic             dvalid;
        logic [CntW-1:0]  dcount;
        logic             ovf;
        logic             last;
    } t_map_res;

    // compression predictor and expected map results
    class map_scoreboard;
        logic [IdW-1:0] held_ids[$];
        logic           ovf_seen;
        t_map_res       pending[$];
        int             errors;

        function new();
            ovf_seen = 1'b0;
            errors   = 0;
        endfunction

        // note one accepted request, compute the set when it closes
        function void note_request(logic [IdW-1:0] id, logic last);
            logic [IdW-1:0] sorted[$];
            logic [IdW-1:0] uniq[$];
            logic [IdW-1:0] prev;
            t_map_res r;
            int n;
            if (held_ids.size() < MaxIds) held_ids.push_back(id);
            else ovf_seen = 1'b1;
            if (!last) return;
            sorted = held_ids;
            sorted.sort();
            prev = '0;
            foreach (sorted[k]) begin
                if (sorted[k] != prev) begin
                    prev = sorted[k];
                    uniq.push_back(sorted[k]);
                end
            end
            n = held_ids.size();
            for (int i = 0; i < n; i++) begin
                r.position = i[PosW-1:0];
                r.cidx     = {CidxW{1'b1}};
                foreach (uniq[k]) if (uniq[k] == held_ids[i]) r.cidx = k[CidxW-1:0];
                r.dvalid   = (i < uniq.size());
                r.did      = r.dvalid ? uniq[i] : '0;
                r.dcount   = CntW'(uniq.size());
                r.ovf      = ovf_seen;
                r.last     = (i == n - 1);
                pending.push_back(r);
            end
            held_ids.delete();
            ovf_seen = 1'b0;
        endfunction

        // compare one result with the oldest expectation
        function void check_result(t_map_res a);
            t_map_res e;
            if (pending.size() == 0) begin
                $error("unexpected result at position %0d", a.position);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.position !== e.position) begin
                $error("position exp %0d got %0d", e.position, a.position); errors++;
            end
            if (a.cidx !== e.cidx) begin
                $error("compressed_index exp %0h got %0h", e.cidx, a.cidx); errors++;
            end
            if (a.did !== e.did) begin
                $error("distinct_id exp %0h got %0h", e.did, a.did); errors++;
            end
            if (a.dvalid !== e.dvalid) begin
                $error("distinct_valid exp %0b got %0b", e.dvalid, a.dvalid); errors++;
            end
            if (a.dcount !== e.dcount) begin
                $error("distinct_count exp %0d got %0d", e.dcount, a.dcount); errors++;
            end
            if (a.ovf !== e.ovf) begin
                $error("overflowed exp %0b got %0b", e.ovf, a.ovf); errors++;
            end
            if (a.last !== e.last) begin
                $error("last_result exp %0b got %0b", e.last, a.last); errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [IdW-1:0]   i_id_value = '0;
    logic             i_is_last = 1'b0;
    logic             o_strobe;
    logic [PosW-1:0]  o_position;
    logic [CidxW-1:0] o_compressed_index;
    logic [IdW-1:0]   o_distinct_id;
    logic             o_distinct_valid;
    logic [CntW-1:0]  o_distinct_count;
    logic             o_overflowed;
    logic             o_last_result;

    map_scoreboard sb = new();
    int            idle_pct = 0;
    int            sent = 0;
    logic [IdW-1:0] id_pool[8];

    id_compress_and_map_core u_dut (.*);

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        t_map_res a;
        if (i_rst_n && o_strobe) begin
            a.position = o_position;
            a.cidx     = o_compressed_index;
            a.did      = o_distinct_id;
            a.dvalid   = o_distinct_valid;
            a.dcount   = o_distinct_count;
            a.ovf      = o_overflowed;
            a.last     = o_last_result;
            sb.check_result(a);
        end
    end

    // send one request, holding start until it is taken
    task automatic send_request(logic [IdW-1:0] id, logic last);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_id_value <= id;
        i_is_last  <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(id, last);
        sent++;
    endtask

    // wait until every expected result has arrived
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // random id, often drawn from a small pool to force duplicates and zeros
    function automatic logic [IdW-1:0] rand_id();
        case ($urandom_range(3))
            0: return '0;
            1: return id_pool[$urandom_range(7)];
            2: return {$urandom, $urandom};
            default: return {32'h0, 24'h0, 8'($urandom)};
        endcase
    endfunction

    // send one set of the given length
    task automatic send_set(int len);
        for (int i = 0; i < len; i++) send_request(rand_id(), i == len - 1);
    endtask

    initial begin
        for (int k = 0; k < 8; k++) id_pool[k] = {$urandom, $urandom};
        id_pool[0] = '1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single zero, single max, duplicates, all-zero set
        send_request('0, 1'b1);
        send_request('1, 1'b1);
        send_request(64'h5, 1'b0);
        send_request(64'h5, 1'b0);
        send_request('1, 1'b0);
        send_request('0, 1'b0);
        send_request(64'h1, 1'b1);
        send_request('0, 1'b0);
        send_request('0, 1'b1);
        wait_drained();
        // store full: overflow with is_last on a dropped request
        for (int i = 0; i < MaxIds + 2; i++)
            send_request({$urandom, $urandom}, i == MaxIds + 1);
        wait_drained();

        // random phases of idling; mostly short sets, a few full ones
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 0) ? 0 : (ph == 3) ? 35 : 74;
            while (sent < 25 + (ph + 1) * 80) begin
                if ($urandom_range(9) == 0) send_set($urandom_range(MaxIds, MaxIds + 3));
                else send_set($urandom_range(1, 6));
            end
            wait_drained();
        end
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("** id_compress_and_map_core: PASSED **");
        end else begin
            $display("** id_compress_and_map_core: FAILED **");
        end
        $finish;
    end

    // run limit
    initial begin
        #8ms;
        $display("** id_compress_and_map_core: FAILED **");
        $finish;
    end
endmodule

>>> files.f
design/icm_pkg.sv
design/icm_dpath.sv
design/icm_ctrl.sv
design/id_compress_and_map_core.sv
test/id_compress_and_map_core_tb.sv
